FILE: hdl/binary_to_padded_decimal_ascii_core_assert.svh
// Assertion macros for the padded decimal converter.
// They refer to clk and rst_n of the module that uses them.
`ifndef BINARY_TO_PADDED_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_PADDED_DECIMAL_ASCII_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPD_ASSERT_IMPL(lbl, ante, cons)
`define BPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/bpd_pkg.sv
package bpd_pkg;

  localparam int BPD_NDIG = 10;
  localparam int BPD_VW = 32;
  localparam int BPD_STEPS = 8;
  localparam int BPD_NSTG = BPD_VW / BPD_STEPS;
  localparam logic [4:0] BPD_MAX_WIDTH = 5'd29;
  localparam logic [4:0] BPD_WIDTH_RST = 5'd10;
  localparam logic [5:0] BPD_ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic [4*BPD_NDIG-1:0] bcd;
    logic [BPD_VW-1:0]     bin;
  } bpd_dd_t;

  // eight shift-add-3 steps of the double dabble conversion
  function automatic bpd_dd_t bpd_dd_steps(bpd_dd_t s);
    bpd_dd_t r;
    r = s;
    for (int k = 0; k < BPD_STEPS; k++) begin
      for (int j = 0; j < BPD_NDIG; j++) begin
        if (r.bcd[4*j +: 4] >= 4'd5) begin
          r.bcd[4*j +: 4] = r.bcd[4*j +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[4*BPD_NDIG-2:0], r.bin[BPD_VW-1]};
      r.bin = {r.bin[BPD_VW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: hdl/bpd_dd_stage.sv
module bpd_dd_stage
  import bpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_vld,
  input  bpd_dd_t up_dat,
  output logic    up_rdy,
  output logic    dn_vld,
  output bpd_dd_t dn_dat,
  input  logic    dn_rdy
);

  logic    vld_r;
  bpd_dd_t dat_r;

  assign up_rdy = !vld_r || dn_rdy;
  assign dn_vld = vld_r;
  assign dn_dat = dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      dat_r <= bpd_dd_steps(up_dat);
    end
  end

endmodule

FILE: hdl/binary_to_padded_decimal_ascii_core.sv
// Path: four double dabble stage registers, then bcd_r, then out_char_r.
// Throughput: one character per cycle while out_stall is low; an item is
// field_width characters at the output (capped at 29, 10 after reset).
// Four double dabble stages, 8 bits each, take an item every cycle if not held.
// Reset (rst_n, synchronous): pipeline emptied, field_width back to 10.
`include "binary_to_padded_decimal_ascii_core_assert.svh"

module binary_to_padded_decimal_ascii_core
  import bpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_digit_char,
  output logic        out_last,
  output logic        out_fits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  logic [4:0] field_width_r;
  logic [4:0] eff_w;

  logic    s_vld [BPD_NSTG+1];
  logic    s_rdy [BPD_NSTG+1];
  bpd_dd_t s_dat [BPD_NSTG+1];

  logic                  busy_r;
  logic [4:0]            place_r;
  logic [4*BPD_NDIG-1:0] bcd_r;
  logic                  fits_r;
  logic                  out_vld_r;
  logic [5:0]            out_char_r;
  logic                  out_last_r;
  logic                  out_fits_r;

  logic       mv;
  logic       ser_rdy;
  logic       ld;
  logic       ld_fits;
  logic [3:0] cur_dig;

  assign cfg_ready = 1'b1;
  assign eff_w = (field_width_r > BPD_MAX_WIDTH) ? BPD_MAX_WIDTH : field_width_r;

  assign s_vld[0]     = in_valid;
  assign s_dat[0].bcd = '0;
  assign s_dat[0].bin = in_value;
  assign in_stall     = !s_rdy[0];

  for (genvar k = 0; k < BPD_NSTG; k++) begin : g_stg
    bpd_dd_stage u_stg (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_vld (s_vld[k]),
      .up_dat (s_dat[k]),
      .up_rdy (s_rdy[k]),
      .dn_vld (s_vld[k+1]),
      .dn_dat (s_dat[k+1]),
      .dn_rdy (s_rdy[k+1])
    );
  end

  assign mv      = busy_r && (!out_vld_r || !out_stall);
  assign ser_rdy = !busy_r || (mv && (place_r == 5'd0));
  assign s_rdy[BPD_NSTG] = ser_rdy;
  assign ld      = s_vld[BPD_NSTG] && ser_rdy;

  always_comb begin
    ld_fits = 1'b1;
    for (int j = 0; j < BPD_NDIG; j++) begin
      if ((5'(j) >= eff_w) && (s_dat[BPD_NSTG].bcd[4*j +: 4] != 4'd0)) begin
        ld_fits = 1'b0;
      end
    end
  end

  always_comb begin
    cur_dig = 4'd0;
    if (place_r < 5'(BPD_NDIG)) begin
      cur_dig = bcd_r[{place_r[3:0], 2'b00} +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r <= BPD_WIDTH_RST;
      busy_r        <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        field_width_r <= cfg_data;
      end
      if (!out_vld_r || !out_stall) begin
        out_vld_r <= mv;
      end
      if (mv && (place_r == 5'd0)) begin
        busy_r <= 1'b0;
      end
      if (ld) begin
        busy_r <= (eff_w != 5'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      out_char_r <= BPD_ASCII_ZERO + {2'b00, cur_dig};
      out_last_r <= (place_r == 5'd0);
      out_fits_r <= fits_r;
      place_r    <= place_r - 5'd1;
    end
    if (ld) begin
      place_r <= eff_w - 5'd1;
      bcd_r   <= s_dat[BPD_NSTG].bcd;
      fits_r  <= ld_fits;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_fits       = out_fits_r;

  `BPD_ASSERT_IMPL(a_place_range, busy_r, place_r < eff_w)
  `BPD_ASSERT_NEXT(a_last_char, mv && (place_r == 5'd0), out_vld_r && out_last_r)
  `BPD_ASSERT_IMPL(a_wide_fits, out_vld_r && (eff_w >= 5'(BPD_NDIG)), out_fits_r)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bpd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLDOFF_LEN  = 300;
  localparam int RAND_W       = -1;
  localparam int N_DIR        = 21;
  localparam int N_PHASE      = 9;

  typedef enum {MODE_RECV_HEAVY, MODE_SEND_HEAVY, MODE_NO_IDLE} idle_mode_t;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
    logic       fits;
  } dec_char_t;

  typedef struct {
    logic [4:0]  width;
    logic [31:0] value;
    bit          typed;
    string       txt;
    logic        fits;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_digit_char;
  logic        out_last;
  logic        out_fits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  dec_char_t   pending_chars[$];
  dec_char_t   want;
  logic [4:0]  model_width;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;

  dir_row_t dir_tab [N_DIR] = '{
    '{5'd10, 32'd0,          1'b1, "0000000000", 1'b1},
    '{5'd10, 32'hFFFFFFFF,   1'b1, "4294967295", 1'b1},
    '{5'd10, 32'd1,          1'b1, "0000000001", 1'b1},
    '{5'd10, 32'd999999999,  1'b1, "0999999999", 1'b1},
    '{5'd10, 32'd1000000000, 1'b1, "1000000000", 1'b1},
    '{5'd10, 32'd12345678,   1'b0, "",           1'b0},
    '{5'd1,  32'd9,          1'b1, "9",          1'b1},
    '{5'd1,  32'd10,         1'b1, "0",          1'b0},
    '{5'd1,  32'd0,          1'b1, "0",          1'b1},
    '{5'd1,  32'hFFFFFFFF,   1'b1, "5",          1'b0},
    '{5'd29, 32'hFFFFFFFF,   1'b1, "00000000000000000004294967295", 1'b1},
    '{5'd29, 32'd0,          1'b1, "00000000000000000000000000000", 1'b1},
    '{5'd31, 32'h80000000,   1'b1, "00000000000000000002147483648", 1'b1},
    '{5'd30, 32'd7,          1'b0, "",           1'b0},
    '{5'd0,  32'hFFFFFFFF,   1'b1, "",           1'b0},
    '{5'd0,  32'd0,          1'b1, "",           1'b0},
    '{5'd9,  32'd999999999,  1'b1, "999999999",  1'b1},
    '{5'd9,  32'd1000000000, 1'b1, "000000000",  1'b0},
    '{5'd9,  32'hFFFFFFFF,   1'b1, "294967295",  1'b0},
    '{5'd10, 32'hAAAAAAAA,   1'b0, "",           1'b0},
    '{5'd10, 32'h55555555,   1'b0, "",           1'b0}
  };

  int ph_width [N_PHASE] = '{4, 29, 0, 31, 1, RAND_W, 10, 30, RAND_W};
  int ph_items [N_PHASE] = '{30, 25, 8, 20, 40, 30, 30, 20, 32};

  binary_to_padded_decimal_ascii_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last      (out_last),
    .out_fits      (out_fits),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLDOFF_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected item: char %0d last %0b fits %0b",
                   out_digit_char, out_last, out_fits);
      end else begin
        want = pending_chars.pop_front();
        if (out_digit_char !== want.ch || out_last !== want.last ||
            out_fits !== want.fits) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: char %0d/%0d last %0b/%0b fits %0b/%0b (exp/act)",
                     want.ch, out_digit_char, want.last, out_last,
                     want.fits, out_fits);
        end
      end
    end
  end

  task automatic set_idle_mode(input idle_mode_t m);
    case (m)
      MODE_RECV_HEAVY: begin
        send_idle_pct = 14;
        recv_idle_pct = 79;
      end
      MODE_SEND_HEAVY: begin
        send_idle_pct = 79;
        recv_idle_pct = 14;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // zero-padded decimal run of v at the current width
  task automatic push_decimal_run(input logic [31:0] v);
    int         w;
    logic [3:0] digs [29];
    logic [31:0] rest;
    logic       fits;
    w = (model_width > BPD_MAX_WIDTH) ? int'(BPD_MAX_WIDTH) : int'(model_width);
    rest = v;
    for (int i = w; i > 0; i--) begin
      digs[i-1] = 4'(rest % 32'd10);
      rest = rest / 32'd10;
    end
    fits = (rest == 32'd0);
    for (int i = 0; i < w; i++)
      pending_chars.push_back('{BPD_ASCII_ZERO + {2'b00, digs[i]}, (i == w - 1), fits});
  endtask

  task automatic push_typed_run(input string txt, input logic fits);
    logic [7:0] c;
    for (int i = 0; i < txt.len(); i++) begin
      c = txt[i];
      pending_chars.push_back('{c[5:0], (i == txt.len() - 1), fits});
    end
  endtask

  task automatic send_value(input logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_field_width(input logic [4:0] w);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_width = w;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 999);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return p - 32'($urandom_range(0, 1));
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [31:0] v;
    int          w;
    model_width = BPD_WIDTH_RST;
    set_idle_mode(MODE_RECV_HEAVY);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_tab[r].width != model_width)
        set_field_width(dir_tab[r].width);
      send_value(dir_tab[r].value);
      if (dir_tab[r].typed)
        push_typed_run(dir_tab[r].txt, dir_tab[r].fits);
      else
        push_decimal_run(dir_tab[r].value);
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      w = (ph_width[ph] == RAND_W) ? $urandom_range(0, 31) : ph_width[ph];
      set_field_width(5'(w));
      set_idle_mode(idle_mode_t'(ph / 3));
      for (int n = 0; n < ph_items[ph]; n++) begin
        if (n == 5 && (ph == 0 || ph == 6))
          hold_req = hold_req + 1;
        if (n == 20 && ph == 4) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_chars.size() != 0);
        end
        v = pick_value();
        send_value(v);
        push_decimal_run(v);
      end
    end

    drain_pipeline();
    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
